FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by scd_frame and scd_decode
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg
// constants, types and functions for the scratchpad crc decoder
// ---------------------------------------------------------------------------
package scd_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 9;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // byte positions within the frame
    localparam logic [IDX_W-1:0] IDX_TEMP_LO = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_TEMP_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_HIGH_LIM = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_LOW_LIM = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CONFIG  = IDX_W'(4);

    // reflected crc-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // configuration byte codes
    localparam logic [7:0] CFG_RES_9  = 8'h1F;
    localparam logic [7:0] CFG_RES_10 = 8'h3F;
    localparam logic [7:0] CFG_RES_11 = 8'h5F;

    // resolution codes
    localparam logic [3:0] RES_9  = 4'd9;
    localparam logic [3:0] RES_10 = 4'd10;
    localparam logic [3:0] RES_11 = 4'd11;
    localparam logic [3:0] RES_12 = 4'd12;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // completed frame passed from the accumulator to the decoder
    typedef struct packed {
        logic        bad;
        logic [15:0] temp_raw;
        logic [7:0]  high_limit;
        logic [7:0]  low_limit;
        logic [7:0]  config_byte;
    } t_frame_rec;

    // one byte of the reflected crc, lsb first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ data[i];
            crc = {1'b0, crc[7:1]};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // resolution from configuration byte, 12 bits for unknown codes
    function automatic logic [3:0] decode_res(input logic [7:0] cfg);
        logic [3:0] res;
        unique case (cfg)
            CFG_RES_9:  res = RES_9;
            CFG_RES_10: res = RES_10;
            CFG_RES_11: res = RES_11;
            default:    res = RES_12;
        endcase
        return res;
    endfunction

    // magnitude mask for a resolution
    function automatic logic [10:0] res_mask(input logic [3:0] res);
        logic [10:0] mask;
        unique case (res)
            RES_9:   mask = 11'h7F8;
            RES_10:  mask = 11'h7FC;
            RES_11:  mask = 11'h7FE;
            default: mask = 11'h7FF;
        endcase
        return mask;
    endfunction

endpackage

FILE: src/scd_frame.sv
// ---------------------------------------------------------------------------
// scd_frame
// byte accumulator: tracks frame position, runs the crc, holds the data
// bytes and registers a completed frame record on the final byte
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    output logic                o_rec_valid,
    input  logic                i_rec_ready,
    output scd_pkg::t_frame_rec o_rec
);

    logic [scd_pkg::IDX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]                r_crc, n_crc;
    logic [7:0]                r_temp_lo, r_temp_hi, r_high_lim, r_low_lim, r_config;
    logic                      r_rec_valid, n_rec_valid;
    scd_pkg::t_frame_rec       r_rec;

    logic                      accept;
    logic                      last;
    logic [scd_pkg::IDX_W-1:0] eff_index;
    logic [7:0]                eff_crc;

    // a frame record can move on when the slot is free or being drained
    assign o_ready = !r_rec_valid || i_rec_ready;
    assign accept  = i_valid && o_ready;

    // position and crc seen by this item, after an optional restart
    assign eff_index = i_frame_start ? '0 : r_byte_index;
    assign eff_crc   = i_frame_start ? 8'h00 : r_crc;
    assign last      = eff_index >= scd_pkg::LAST_IDX;

    // next frame position and crc
    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        if (accept) begin
            if (last) begin
                n_byte_index = '0;
                n_crc        = 8'h00;
            end else begin
                n_byte_index = eff_index + 1'b1;
                n_crc        = scd_pkg::crc_byte(eff_crc, i_rx_byte);
            end
        end
    end

    // record slot occupancy
    always_comb begin
        n_rec_valid = r_rec_valid;
        if (accept && last) begin
            n_rec_valid = 1'b1;
        end else if (i_rec_ready) begin
            n_rec_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= 8'h00;
            r_rec_valid  <= 1'b0;
        end else begin
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_rec_valid  <= n_rec_valid;
        end
    end

    // data bytes held by position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_lo  <= 8'h00;
            r_temp_hi  <= 8'h00;
            r_high_lim <= 8'h00;
            r_low_lim  <= 8'h00;
            r_config   <= 8'h00;
        end else if (accept && !last) begin
            unique case (eff_index)
                scd_pkg::IDX_TEMP_LO:  r_temp_lo  <= i_rx_byte;
                scd_pkg::IDX_TEMP_HI:  r_temp_hi  <= i_rx_byte;
                scd_pkg::IDX_HIGH_LIM: r_high_lim <= i_rx_byte;
                scd_pkg::IDX_LOW_LIM:  r_low_lim  <= i_rx_byte;
                scd_pkg::IDX_CONFIG:   r_config   <= i_rx_byte;
                default: ;
            endcase
        end
    end

    // frame record on the final byte
    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_rec.bad         <= i_rx_byte != eff_crc;
            r_rec.temp_raw    <= {r_temp_hi, r_temp_lo};
            r_rec.high_limit  <= r_high_lim;
            r_rec.low_limit   <= r_low_lim;
            r_rec.config_byte <= r_config;
        end
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    // checks
    `ASSERT_ALWAYS(a_index_range, i_clk, i_rst_n, r_byte_index <= scd_pkg::LAST_IDX, "frame index past last byte")
    `ASSERT_NEXT(a_restart_after_last, i_clk, i_rst_n, accept && last, (r_byte_index == '0) && (r_crc == 8'h00) && r_rec_valid, "frame not restarted after final byte")
    `ASSERT_NEXT(a_rec_held, i_clk, i_rst_n, r_rec_valid && !i_rec_ready, r_rec_valid && $stable(r_rec), "pending frame record lost")

endmodule

FILE: src/scd_decode.sv
// ---------------------------------------------------------------------------
// scd_decode
// result stage: decodes temperature and resolution from a frame record
// and holds the result item until it is taken
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    output logic                o_rec_ready,
    input  scd_pkg::t_frame_rec i_rec,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic signed [11:0]  o_temperature_sixteenths,
    output logic [7:0]          o_high_limit,
    output logic [7:0]          o_low_limit,
    output logic [7:0]          o_config_byte,
    output logic [3:0]          o_resolution_bits
);

    logic               r_valid, n_valid;
    logic               r_status;
    logic signed [11:0] r_temp;
    logic [7:0]         r_high_lim, r_low_lim, r_config;
    logic [3:0]         r_res;

    logic               take;
    logic               neg;
    logic [3:0]         res;
    logic [10:0]        mag;
    logic [11:0]        temp;

    assign o_rec_ready = !r_valid || i_ready;
    assign take        = i_rec_valid && o_rec_ready;

    // sign-magnitude decode with resolution masking
    always_comb begin
        neg  = i_rec.temp_raw[15];
        res  = scd_pkg::decode_res(i_rec.config_byte);
        mag  = neg ? (11'd0 - i_rec.temp_raw[10:0]) : i_rec.temp_raw[10:0];
        mag  = mag & scd_pkg::res_mask(res);
        temp = neg ? (12'd0 - {1'b0, mag}) : {1'b0, mag};
    end

    // result occupancy
    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload, zeroed on a crc mismatch
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (i_rec.bad) begin
                r_status   <= scd_pkg::STATUS_BAD;
                r_temp     <= '0;
                r_high_lim <= 8'h00;
                r_low_lim  <= 8'h00;
                r_config   <= 8'h00;
                r_res      <= 4'd0;
            end else begin
                r_status   <= scd_pkg::STATUS_OK;
                r_temp     <= $signed(temp);
                r_high_lim <= i_rec.high_limit;
                r_low_lim  <= i_rec.low_limit;
                r_config   <= i_rec.config_byte;
                r_res      <= res;
            end
        end
    end

    assign o_valid                  = r_valid;
    assign o_status                 = r_status;
    assign o_temperature_sixteenths = r_temp;
    assign o_high_limit             = r_high_lim;
    assign o_low_limit              = r_low_lim;
    assign o_config_byte            = r_config;
    assign o_resolution_bits        = r_res;

    // checks
    `ASSERT_IMPLIES(a_bad_zeroed, i_clk, i_rst_n, r_valid && (r_status == scd_pkg::STATUS_BAD), (r_temp == '0) && (r_high_lim == 8'h00) && (r_low_lim == 8'h00) && (r_config == 8'h00) && (r_res == 4'd0), "mismatch result carries data")
    `ASSERT_IMPLIES(a_res_range, i_clk, i_rst_n, r_valid && (r_status == scd_pkg::STATUS_OK), (r_res == scd_pkg::RES_9) || (r_res == scd_pkg::RES_10) || (r_res == scd_pkg::RES_11) || (r_res == scd_pkg::RES_12), "resolution out of range")
    `ASSERT_NEXT(a_take_shows, i_clk, i_rst_n, take, r_valid, "taken frame record gives no result")

endmodule

FILE: src/sensor_scratchpad_crc_decoder.sv
// ---------------------------------------------------------------------------
// sensor_scratchpad_crc_decoder
// temperature sensor scratchpad frame decoder with crc-8 check
// ---------------------------------------------------------------------------
// One received byte is taken per cycle while o_ready is high, frames back
// to back without gaps. Byte 0 of a frame is marked by i_frame_start, or
// follows the last byte of the previous frame. The reflected crc-8 runs
// over all bytes but the last; the last byte is compared with it and one
// result item appears on o_valid once that byte is accepted, passing the
// frame record register of the byte accumulator and then the result
// register of the decoder. Throughput is one byte per cycle while results
// are taken; the record and result registers absorb a stall of the output
// side before i_ready/o_ready backpressure reaches the input.

module sensor_scratchpad_crc_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output logic signed [11:0] o_temperature_sixteenths,
    output logic [7:0]         o_high_limit,
    output logic [7:0]         o_low_limit,
    output logic [7:0]         o_config_byte,
    output logic [3:0]         o_resolution_bits
);

    logic                rec_valid;
    logic                rec_ready;
    scd_pkg::t_frame_rec rec;

    // byte accumulation and crc
    scd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_rec_valid   (rec_valid),
        .i_rec_ready   (rec_ready),
        .o_rec         (rec)
    );

    // decode and result register
    scd_decode u_decode (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_rec_valid              (rec_valid),
        .o_rec_ready              (rec_ready),
        .i_rec                    (rec),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_status                 (o_status),
        .o_temperature_sixteenths (o_temperature_sixteenths),
        .o_high_limit             (o_high_limit),
        .o_low_limit              (o_low_limit),
        .o_config_byte            (o_config_byte),
        .o_resolution_bits        (o_resolution_bits)
    );

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the scratchpad crc decoder: bytes of sensor frames
// go in over valid/ready, each accepted byte runs through a local decoder
// model, and every result item is checked field by field in arrival order
// ---------------------------------------------------------------------------
module tb;

    // one byte on the input channel
    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         drain;
    } t_sensor_byte;

    // one decoded reading
    typedef struct packed {
        logic        status;
        logic [11:0] temp;
        logic [7:0]  high_lim;
        logic [7:0]  low_lim;
        logic [7:0]  cfg;
        logic [3:0]  res;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_status;
    logic signed [11:0] o_temperature_sixteenths;
    logic [7:0]         o_high_limit;
    logic [7:0]         o_low_limit;
    logic [7:0]         o_config_byte;
    logic [3:0]         o_resolution_bits;

    t_sensor_byte tx_bytes[$];
    t_reading     expected_readings[$];

    // counters shared between processes; all but err_cnt are updated with nonblocking writes
    int unsigned sent_cnt = 0;
    int unsigned due_cnt = 0;
    int unsigned seen_cnt = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int          err_cnt = 0;
    logic        calm;

    // decoder model state
    logic [3:0] pos = 4'd0;
    logic [7:0] crc_acc = 8'h00;
    logic [7:0] temp_lo_q = 8'h00;
    logic [7:0] temp_hi_q = 8'h00;
    logic [7:0] high_lim_q = 8'h00;
    logic [7:0] low_lim_q = 8'h00;
    logic [7:0] cfg_q = 8'h00;

    // stimulus builder state
    bit drain_next = 1'b0;
    int queued = 0;

    sensor_scratchpad_crc_decoder i_dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_rx_byte                (i_rx_byte),
        .i_frame_start            (i_frame_start),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_status                 (o_status),
        .o_temperature_sixteenths (o_temperature_sixteenths),
        .o_high_limit             (o_high_limit),
        .o_low_limit              (o_low_limit),
        .o_config_byte            (o_config_byte),
        .o_resolution_bits        (o_resolution_bits)
    );

    always #1 i_clk = ~i_clk;

    // no idling on either side in this window
    assign calm = (sent_cnt >= 550) && (sent_cnt < 700);

    // reflected crc-8, lsb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c[0] ^ b[k]) ? ((c >> 1) ^ scd_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // feed one accepted byte to the model, returns 1 when it closes a frame
    function automatic bit absorb_byte(input logic [7:0] b, input logic fs);
        t_reading    rd;
        logic [15:0] raw;
        logic [15:0] mag16;
        logic [10:0] mag;
        logic [3:0]  res;
        if (fs) begin
            pos = 4'd0;
            crc_acc = 8'h00;
        end
        if (pos >= 4'(scd_pkg::FRAME_BYTES - 1)) begin
            rd = '0;
            if (b != crc_acc) begin
                rd.status = scd_pkg::STATUS_BAD;
            end else begin
                rd.status = scd_pkg::STATUS_OK;
                case (cfg_q)
                    scd_pkg::CFG_RES_9:  res = scd_pkg::RES_9;
                    scd_pkg::CFG_RES_10: res = scd_pkg::RES_10;
                    scd_pkg::CFG_RES_11: res = scd_pkg::RES_11;
                    default:             res = scd_pkg::RES_12;
                endcase
                raw = {temp_hi_q, temp_lo_q};
                // sign and magnitude, then drop low bits by resolution
                mag16 = raw[15] ? (16'h0000 - raw) : raw;
                mag = mag16[10:0] & (11'h7FF << (scd_pkg::RES_12 - res));
                rd.temp = raw[15] ? (12'h000 - {1'b0, mag}) : {1'b0, mag};
                rd.high_lim = high_lim_q;
                rd.low_lim = low_lim_q;
                rd.cfg = cfg_q;
                rd.res = res;
            end
            expected_readings.push_back(rd);
            pos = 4'd0;
            crc_acc = 8'h00;
            return 1'b1;
        end
        case (pos)
            4'(scd_pkg::IDX_TEMP_LO):  temp_lo_q = b;
            4'(scd_pkg::IDX_TEMP_HI):  temp_hi_q = b;
            4'(scd_pkg::IDX_HIGH_LIM): high_lim_q = b;
            4'(scd_pkg::IDX_LOW_LIM):  low_lim_q = b;
            4'(scd_pkg::IDX_CONFIG):   cfg_q = b;
            default: ;
        endcase
        crc_acc = crc8_step(crc_acc, b);
        pos = pos + 4'd1;
        return 1'b0;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic fs);
        tx_bytes.push_back('{data: b, start: fs, drain: drain_next});
        drain_next = 1'b0;
        queued++;
    endtask

    // full frame from byte 0, last byte a good or a corrupted crc
    task automatic queue_frame(input logic [15:0] raw, input logic [7:0] hl,
                               input logic [7:0] ll, input logic [7:0] cfg,
                               input bit marked, input bit crc_ok);
        logic [7:0] body [scd_pkg::FRAME_BYTES-1];
        logic [7:0] crc;
        body[0] = raw[7:0];
        body[1] = raw[15:8];
        body[2] = hl;
        body[3] = ll;
        body[4] = cfg;
        for (int k = 5; k < scd_pkg::FRAME_BYTES - 1; k++) begin
            body[k] = 8'($urandom);
        end
        crc = 8'h00;
        for (int k = 0; k < scd_pkg::FRAME_BYTES - 1; k++) begin
            crc = crc8_step(crc, body[k]);
            queue_byte(body[k], (k == 0) ? marked : 1'b0);
        end
        queue_byte(crc_ok ? crc : (crc ^ 8'($urandom_range(255, 1))), 1'b0);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(4))
            0: return 16'($urandom_range(16'h07FF));
            1: return 16'($urandom_range(16'hFFFF, 16'hF800));
            2: begin
                case ($urandom_range(5))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h8000;
                    3: return 16'h07FF;
                    4: return 16'hF801;
                    default: return 16'h7FFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_cfg();
        case ($urandom_range(4))
            0: return scd_pkg::CFG_RES_9;
            1: return scd_pkg::CFG_RES_10;
            2: return scd_pkg::CFG_RES_11;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // sender: offers queued bytes, idles at random, feeds the model on accept
    always @(posedge i_clk) begin : drive_bytes
        t_sensor_byte nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (absorb_byte(i_rx_byte, i_frame_start)) begin
                    due_cnt <= due_cnt + 1;
                end
                sent_cnt <= sent_cnt + 1;
            end
            if (!i_valid || o_ready) begin
                if (tx_bytes.size() == 0 || (!calm && $urandom_range(99) < 24)) begin
                    i_valid <= 1'b0;
                end else if (tx_bytes[0].drain && (i_valid || due_cnt != seen_cnt)) begin
                    // hold this item back until all readings are out
                    i_valid <= 1'b0;
                end else begin
                    nxt = tx_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_rx_byte <= nxt.data;
                    i_frame_start <= nxt.start;
                end
            end
        end
    end

    // receiver: checks readings, stalls at random and once for a long stretch
    always @(posedge i_clk) begin : collect_readings
        t_reading want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                seen_cnt <= seen_cnt + 1;
                if (expected_readings.size() == 0) begin
                    $error("reading with nothing expected: status %0d temp %0d",
                           o_status, o_temperature_sixteenths);
                    err_cnt++;
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("status", want.status, o_status);
                    compare_field("temperature_sixteenths", $signed(want.temp),
                                  o_temperature_sixteenths);
                    compare_field("high_limit", want.high_lim, o_high_limit);
                    compare_field("low_limit", want.low_lim, o_low_limit);
                    compare_field("config_byte", want.cfg, o_config_byte);
                    compare_field("resolution_bits", want.res, o_resolution_bits);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (!hold_done && sent_cnt >= 300) begin
                hold_done <= 1'b1;
                hold_left <= 150;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= 24);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int frames;
        int r;
        bit need_mark;

        // partial frame dropped by the next start mark
        queue_byte(8'hA5, 1'b1);
        // negative zero at 9-bit resolution
        queue_frame(16'h8000, 8'h4B, 8'h46, scd_pkg::CFG_RES_9, 1'b1, 1'b1);
        // frame without start mark, bad crc
        queue_frame(16'h07FF, 8'hFF, 8'h00, scd_pkg::CFG_RES_11, 1'b0, 1'b0);
        // minus one sixteenth at 10-bit resolution, unmarked
        queue_frame(16'hFFFF, 8'h7F, 8'h80, scd_pkg::CFG_RES_10, 1'b0, 1'b1);

        // random part: mostly whole frames, some cut short, some noise
        frames = 0;
        need_mark = 1'b0;
        while (queued < 925) begin
            r = $urandom_range(99);
            if (r < 80) begin
                frames++;
                if (frames == 40 || frames == 90) begin
                    drain_next = 1'b1;
                end
                queue_frame(pick_raw(), 8'($urandom), 8'($urandom), pick_cfg(),
                            need_mark || $urandom_range(1), $urandom_range(99) < 80);
                need_mark = 1'b0;
            end else if (r < 90) begin
                queue_byte(8'($urandom), 1'b1);
                repeat ($urandom_range(scd_pkg::FRAME_BYTES - 3)) begin
                    queue_byte(8'($urandom), 1'b0);
                end
                need_mark = 1'b1;
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    queue_byte(8'($urandom), 1'($urandom));
                end
                need_mark = 1'b1;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (tx_bytes.size() != 0 || i_valid || due_cnt != seen_cnt);
        repeat (8) @(posedge i_clk);

        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("sensor_scratchpad_crc_decoder: match");
        end else begin
            $display("sensor_scratchpad_crc_decoder: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("sensor_scratchpad_crc_decoder: mismatch");
        $finish;
    end

endmodule
